// ===== src/strict_priority_multi_queue_top_defines.svh =====
// Assertion helpers used by the queue controller.
// Each helper samples on clk and is disabled while arst_n is low.
`ifndef STRICT_PRIORITY_MULTI_QUEUE_TOP_DEFINES_SVH
`define STRICT_PRIORITY_MULTI_QUEUE_TOP_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define SPMQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spmq assertion failed");

// Check a condition in the cycle after its trigger.
`define SPMQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spmq assertion failed");

`endif

// ===== src/spmq_pkg.sv =====
`default_nettype none

package spmq_pkg;

	localparam int NUM_LEVELS_DEF  = 4;
	localparam int LEVEL_DEPTH_DEF = 16;

	localparam int JOB_W       = 32;
	localparam int PRIO_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SEND
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic exec;      // carry out the accepted request
		logic load_job;  // capture the job word read from the store
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pop_ok;    // current request is a pop that finds a job
	} stat_t;

endpackage

`default_nettype wire

// ===== src/spmq_ram.sv =====
`default_nettype none

module spmq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/spmq_ctrl.sv =====
`default_nettype none
`include "strict_priority_multi_queue_top_defines.svh"

module spmq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output spmq_pkg::cmd_t cmd,
	input  spmq_pkg::stat_t stat
);

	spmq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spmq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		m_tvalid     = 1'b0;
		cmd.exec     = 1'b0;
		cmd.load_job = 1'b0;
		case (state_q)
			spmq_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.exec = 1'b1;
					state_d  = stat.pop_ok ? spmq_pkg::ST_READ : spmq_pkg::ST_SEND;
				end
			end
			spmq_pkg::ST_READ: begin
				cmd.load_job = 1'b1;
				state_d      = spmq_pkg::ST_SEND;
			end
			spmq_pkg::ST_SEND: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = spmq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = spmq_pkg::ST_IDLE;
			end
		endcase
	end

	`SPMQ_ASSERT_NOW(a_one_side, s_tready, !m_tvalid)
	`SPMQ_ASSERT_NEXT(a_pop_reads, cmd.exec && stat.pop_ok, cmd.load_job)
	`SPMQ_ASSERT_NEXT(a_read_sends, cmd.load_job, m_tvalid)
	`SPMQ_ASSERT_NEXT(a_taken_idle, m_tvalid && m_tready, s_tready)

endmodule

`default_nettype wire

// ===== src/spmq_dp.sv =====
`default_nettype none

module spmq_dp #(
	parameter int NUM_LEVELS  = spmq_pkg::NUM_LEVELS_DEF,
	parameter int LEVEL_DEPTH = spmq_pkg::LEVEL_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spmq_pkg::cmd_t                cmd,
	output spmq_pkg::stat_t               stat,
	input  logic                          req_type,
	input  logic [spmq_pkg::PRIO_W-1:0]   priority_req,
	input  logic [spmq_pkg::JOB_W-1:0]    job_word,
	output logic [spmq_pkg::JOB_W-1:0]    job_out,
	output logic [1:0]                    job_level,
	output logic [spmq_pkg::STATUS_W-1:0] status,
	output logic                          all_empty
);

	localparam int LW = $clog2(NUM_LEVELS);
	localparam int PW = $clog2(LEVEL_DEPTH);
	localparam int CW = $clog2(LEVEL_DEPTH + 1);

	logic [PW-1:0] head_q  [NUM_LEVELS];
	logic [PW-1:0] tail_q  [NUM_LEVELS];
	logic [CW-1:0] count_q [NUM_LEVELS];
	logic [CW-1:0] count_d [NUM_LEVELS];

	logic [LW-1:0] push_lvl, pop_lvl;
	logic          in_range, push_ok, found, pop_ok, empty_d;
	logic          do_push, do_pop;
	logic [LW+PW-1:0] addr;
	logic [spmq_pkg::JOB_W-1:0] rdata;

	logic [spmq_pkg::JOB_W-1:0]    job_q;
	logic [1:0]                    level_q;
	logic [spmq_pkg::STATUS_W-1:0] status_q;
	logic                          empty_q;

	function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
		return (p == PW'(LEVEL_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_comb begin
		push_lvl = LW'(priority_req);
		in_range = int'(priority_req) < NUM_LEVELS;
		push_ok  = (req_type == spmq_pkg::REQ_PUSH) && in_range &&
			(count_q[push_lvl] != CW'(LEVEL_DEPTH));

		// lowest non-empty level wins
		found   = 1'b0;
		pop_lvl = '0;
		for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
			if (count_q[l] != '0) begin
				found   = 1'b1;
				pop_lvl = LW'(l);
			end
		end
		pop_ok = (req_type == spmq_pkg::REQ_POP) && found;

		do_push = cmd.exec && push_ok;
		do_pop  = cmd.exec && pop_ok;

		empty_d = 1'b1;
		for (int l = 0; l < NUM_LEVELS; l++) begin
			count_d[l] = count_q[l];
			if (do_push && (push_lvl == LW'(l))) begin
				count_d[l] = count_q[l] + CW'(1);
			end
			if (do_pop && (pop_lvl == LW'(l))) begin
				count_d[l] = count_q[l] - CW'(1);
			end
			if (count_d[l] != '0) begin
				empty_d = 1'b0;
			end
		end

		addr = (req_type == spmq_pkg::REQ_PUSH) ? {push_lvl, tail_q[push_lvl]}
			: {pop_lvl, head_q[pop_lvl]};
	end

	assign stat.pop_ok = pop_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				head_q[l]  <= '0;
				tail_q[l]  <= '0;
				count_q[l] <= '0;
			end
		end else begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				count_q[l] <= count_d[l];
			end
			if (do_push) begin
				tail_q[push_lvl] <= next_pos(tail_q[push_lvl]);
			end
			if (do_pop) begin
				head_q[pop_lvl] <= next_pos(head_q[pop_lvl]);
			end
		end
	end

	spmq_ram #(
		.WIDTH (spmq_pkg::JOB_W),
		.DEPTH (NUM_LEVELS << PW)
	) u_store (
		.clk   (clk),
		.we    (do_push),
		.re    (do_pop),
		.addr  (addr),
		.wdata (job_word),
		.rdata (rdata)
	);

	// result register: status fields at execute, job word in the following cycle
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			job_q   <= '0;
			level_q <= do_pop ? 2'(pop_lvl) : 2'd0;
			empty_q <= empty_d;
			if (req_type == spmq_pkg::REQ_PUSH) begin
				status_q <= push_ok ? spmq_pkg::STATUS_OK : spmq_pkg::STATUS_FULL;
			end else begin
				status_q <= pop_ok ? spmq_pkg::STATUS_OK : spmq_pkg::STATUS_EMPTY;
			end
		end
		if (cmd.load_job) begin
			job_q <= rdata;
		end
	end

	assign job_out   = job_q;
	assign job_level = level_q;
	assign status    = status_q;
	assign all_empty = empty_q;

endmodule

`default_nettype wire

// ===== src/strict_priority_multi_queue_top.sv =====
// Results: a push or a refused request shows its result in the cycle after the input beat;
//   a successful pop passes through ST_READ first, for the registered store read.
// Requests: one at a time, and the output beat may wait for m_tready; the controller takes
//   the next request beat only after the result beat of the previous one is taken.
// Reset: arst_n clears the state machine, per-level counts and head/tail positions
//   at once; the job store is not cleared, as only occupied entries are ever read.
`default_nettype none

module strict_priority_multi_queue_top #(
	parameter int NUM_LEVELS  = spmq_pkg::NUM_LEVELS_DEF,
	parameter int LEVEL_DEPTH = spmq_pkg::LEVEL_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request side
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [1:0] priority_req, [33:2] job_word, [39:34] zero
	input  logic [spmq_pkg::IN_TDATA_W-1:0]    s_tdata,
	// [0] req_type (0 push, 1 pop)
	input  logic [0:0]                         s_tuser,
	// result side
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [31:0] job_out, [33:32] job_level, [35:34] status, [36] all_empty, [39:37] zero
	output logic [spmq_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	spmq_pkg::cmd_t  cmd;
	spmq_pkg::stat_t stat;

	logic [spmq_pkg::JOB_W-1:0]    job_out;
	logic [1:0]                    job_level;
	logic [spmq_pkg::STATUS_W-1:0] status;
	logic                          all_empty;

	// Controller: take one request beat, run it, then hold the result beat until taken.
	spmq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// Datapath: per-level counts and positions, priority pick, job store, result register.
	spmq_dp #(
		.NUM_LEVELS  (NUM_LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_type     (s_tuser[0]),
		.priority_req (s_tdata[spmq_pkg::PRIO_W-1:0]),
		.job_word     (s_tdata[spmq_pkg::PRIO_W +: spmq_pkg::JOB_W]),
		.job_out      (job_out),
		.job_level    (job_level),
		.status       (status),
		.all_empty    (all_empty)
	);

	// Pack the result beat, lowest field first, zero fill to whole bytes.
	assign m_tdata = {3'b000, all_empty, status, job_level, job_out};

endmodule

`default_nettype wire
